// ----- hw/rtl/sfsg_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfsg_pkg: shared types and constants of the stroke font segment generator
// Holds the font table, geometry constants, register indexes and the
// transform configuration bundle.
// ---------------------------------------------------------------------------
package sfsg_pkg;

   localparam int MAX_CHARS   = 1024;
   localparam int ROM_DEPTH   = 512;
   localparam int ROM_AW      = $clog2(ROM_DEPTH);
   localparam int ROM_ITEMS   = 358;
   localparam int ROM_LIM     = (ROM_ITEMS < ROM_DEPTH) ? ROM_ITEMS : ROM_DEPTH;
   localparam int IDX_DEPTH   = 256;
   localparam int IDX_W       = ROM_AW + 1;
   localparam int MAX_SEGS    = 15;
   localparam int NSEG_W      = $clog2(MAX_SEGS + 1);
   localparam int CELL_TENTHS = 60;

   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;

   localparam logic [1:0] KIND_CONT  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_HEAD  = 2'd2;
   localparam logic [1:0] KIND_END   = 2'd3;

   localparam logic [13:0] ROM_END = 14'h3000;

   localparam logic [2:0] REG_SCALE    = 3'd0;
   localparam logic [2:0] REG_COS      = 3'd1;
   localparam logic [2:0] REG_SIN      = 3'd2;
   localparam logic [2:0] REG_ORIGIN_X = 3'd3;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd4;

   localparam logic [23:0]        SCALE_RESET = 24'd6554;
   localparam logic signed [15:0] COS_RESET   = 16'sd16384;

   typedef struct packed {
      logic [23:0]        scale;
      logic signed [15:0] cos_rot;
      logic signed [15:0] sin_rot;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
   } cfg_type;

   function automatic logic [13:0] pt(input int x, input int y);
      pt = 14'((x << 6) | y);
   endfunction

   function automatic logic [13:0] ns(input int x, input int y);
      ns = 14'h1000 | pt(x, y);
   endfunction

   function automatic logic [13:0] hd(input int c);
      hd = 14'h2000 | 14'(c);
   endfunction

   localparam logic [13:0] GLYPH_TABLE [ROM_ITEMS] = '{
      hd(8'h41), ns(0,0),pt(20,60),pt(40,0), ns(6,18),pt(34,18),
      hd(8'h42), ns(0,0),pt(0,60),pt(30,60),pt(40,50),pt(30,30),pt(0,30),
                 ns(30,30),pt(40,10),pt(30,0),pt(0,0),
      hd(8'h43), ns(40,50),pt(30,60),pt(10,60),pt(0,50),pt(0,10),pt(10,0),pt(30,0),
                 pt(40,10),
      hd(8'h44), ns(0,0),pt(0,60),pt(30,60),pt(40,50),pt(40,10),pt(30,0),pt(0,0),
      hd(8'h45), ns(40,60),pt(0,60),pt(0,0),pt(40,0), ns(0,30),pt(30,30),
      hd(8'h46), ns(40,60),pt(0,60),pt(0,0), ns(0,30),pt(30,30),
      hd(8'h47), ns(40,50),pt(30,60),pt(10,60),pt(0,50),pt(0,10),pt(10,0),pt(30,0),
                 pt(40,10),pt(40,30),pt(20,30),
      hd(8'h48), ns(0,0),pt(0,60), ns(40,0),pt(40,60), ns(0,30),pt(40,30),
      hd(8'h49), ns(10,0),pt(30,0), ns(20,0),pt(20,60), ns(10,60),pt(30,60),
      hd(8'h4A), ns(30,60),pt(30,10),pt(20,0),pt(10,0),pt(0,10),
      hd(8'h4B), ns(0,0),pt(0,60), ns(40,60),pt(0,30),pt(40,0),
      hd(8'h4C), ns(0,60),pt(0,0),pt(40,0),
      hd(8'h4D), ns(0,0),pt(0,60),pt(20,30),pt(40,60),pt(40,0),
      hd(8'h4E), ns(0,0),pt(0,60),pt(40,0),pt(40,60),
      hd(8'h4F), ns(10,0),pt(0,10),pt(0,50),pt(10,60),pt(30,60),pt(40,50),pt(40,10),
                 pt(30,0),pt(10,0),
      hd(8'h50), ns(0,0),pt(0,60),pt(30,60),pt(40,50),pt(40,40),pt(30,30),pt(0,30),
      hd(8'h51), ns(10,0),pt(0,10),pt(0,50),pt(10,60),pt(30,60),pt(40,50),pt(40,10),
                 pt(30,0),pt(10,0), ns(25,15),pt(40,0),
      hd(8'h52), ns(0,0),pt(0,60),pt(30,60),pt(40,50),pt(40,40),pt(30,30),pt(0,30),
                 ns(20,30),pt(40,0),
      hd(8'h53), ns(40,50),pt(30,60),pt(10,60),pt(0,50),pt(0,40),pt(10,30),pt(30,30),
                 pt(40,20),pt(40,10),pt(30,0),pt(10,0),pt(0,10),
      hd(8'h54), ns(0,60),pt(40,60), ns(20,60),pt(20,0),
      hd(8'h55), ns(0,60),pt(0,10),pt(10,0),pt(30,0),pt(40,10),pt(40,60),
      hd(8'h56), ns(0,60),pt(20,0),pt(40,60),
      hd(8'h57), ns(0,60),pt(10,0),pt(20,30),pt(30,0),pt(40,60),
      hd(8'h58), ns(0,0),pt(40,60), ns(0,60),pt(40,0),
      hd(8'h59), ns(0,60),pt(20,30),pt(40,60), ns(20,30),pt(20,0),
      hd(8'h5A), ns(0,60),pt(40,60),pt(0,0),pt(40,0),
      hd(8'h30), ns(10,0),pt(0,10),pt(0,50),pt(10,60),pt(30,60),pt(40,50),pt(40,10),
                 pt(30,0),pt(10,0), ns(0,10),pt(40,50),
      hd(8'h31), ns(10,40),pt(20,60),pt(20,0), ns(10,0),pt(30,0),
      hd(8'h32), ns(0,50),pt(10,60),pt(30,60),pt(40,50),pt(40,40),pt(0,0),pt(40,0),
      hd(8'h33), ns(0,60),pt(40,60),pt(20,30),pt(40,20),pt(40,10),pt(30,0),pt(10,0),
                 pt(0,10),
      hd(8'h34), ns(30,0),pt(30,60),pt(0,20),pt(40,20),
      hd(8'h35), ns(40,60),pt(0,60),pt(0,30),pt(30,30),pt(40,20),pt(40,10),pt(30,0),
                 pt(10,0),pt(0,10),
      hd(8'h36), ns(40,50),pt(30,60),pt(10,60),pt(0,50),pt(0,10),pt(10,0),pt(30,0),
                 pt(40,10),pt(40,20),pt(30,30),pt(0,30),
      hd(8'h37), ns(0,60),pt(40,60),pt(10,0),
      hd(8'h38), ns(10,30),pt(0,40),pt(0,50),pt(10,60),pt(30,60),pt(40,50),pt(40,40),
                 pt(30,30),
                 pt(10,30),pt(0,20),pt(0,10),pt(10,0),pt(30,0),pt(40,10),pt(40,20),
                 pt(30,30),
      hd(8'h39), ns(0,10),pt(10,0),pt(30,0),pt(40,10),pt(40,50),pt(30,60),pt(10,60),
                 pt(0,50),pt(0,40),pt(10,30),pt(40,30),
      hd(8'h2E), ns(18,0),pt(22,0),pt(22,4),pt(18,4),pt(18,0),
      hd(8'h2C), ns(22,6),pt(18,6),pt(18,10),pt(22,10),pt(22,6),pt(16,0),
      hd(8'h2D), ns(10,30),pt(30,30),
      hd(8'h2B), ns(20,15),pt(20,45), ns(5,30),pt(35,30),
      hd(8'h2F), ns(0,0),pt(40,60),
      hd(8'h3A), ns(20,15),pt(20,20), ns(20,40),pt(20,45),
      hd(8'h25), ns(0,0),pt(40,60), ns(5,45),pt(15,45),pt(15,55),pt(5,55),pt(5,45),
                 ns(25,5),pt(35,5),pt(35,15),pt(25,15),pt(25,5),
      hd(8'h3C), ns(40,50),pt(0,30),pt(40,10),
      hd(8'h3E), ns(0,50),pt(40,30),pt(0,10),
      hd(8'hB0), ns(25,50),pt(20,53),pt(20,57),pt(25,60),pt(30,60),pt(35,57),pt(35,53),
                 pt(30,50),pt(25,50),
      hd(8'hD8), ns(10,0),pt(0,10),pt(0,50),pt(10,60),pt(30,60),pt(40,50),pt(40,10),
                 pt(30,0),pt(10,0), ns(0,0),pt(40,60),
      ROM_END
   };

   // font word at a fill address, end marks past the table
   function automatic logic [13:0] font_word(input int addr);
      if (addr < ROM_ITEMS) begin
         font_word = GLYPH_TABLE[addr];
      end else begin
         font_word = ROM_END;
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
      if (v > 37'sd2147483647) begin
         sat32 = 32'sh7FFFFFFF;
      end else if (v < -37'sd2147483648) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

// ----- hw/rtl/sfsg_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfsg_ram: generic single write, single read memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module sfsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/sfsg_xform.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfsg_xform: point placement pipeline
// Four stages: scale, rotate products, rotate sums, round plus origin with
// saturation.
// ---------------------------------------------------------------------------
module sfsg_xform
   import sfsg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [15:0]        pos60,
   input  logic [5:0]         gx,
   input  logic [5:0]         gy,
   input  cfg_type            cfg,
   output logic               done,
   output logic signed [31:0] px,
   output logic signed [31:0] py
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic [39:0]        lx_ff, lx_in;
   logic [29:0]        ly_ff, ly_in;
   logic signed [56:0] p0_ff, p0_in, p2_ff, p2_in;
   logic signed [46:0] p1_ff, p1_in, p3_ff, p3_in;
   logic signed [57:0] rx_ff, rx_in, ry_ff, ry_in;
   logic signed [57:0] rnd_x, rnd_y;
   logic signed [35:0] sh_x, sh_y;
   logic signed [31:0] px_ff, px_in, py_ff, py_in;
   logic [15:0]        u;

   always_comb begin
      u     = pos60 + 16'(gx);
      lx_in = 40'(u) * 40'(cfg.scale);
      ly_in = 30'(gy) * 30'(cfg.scale);
      p0_in = $signed({1'b0, lx_ff}) * cfg.cos_rot;
      p2_in = $signed({1'b0, lx_ff}) * cfg.sin_rot;
      p1_in = $signed({1'b0, ly_ff}) * cfg.sin_rot;
      p3_in = $signed({1'b0, ly_ff}) * cfg.cos_rot;
      rx_in = 58'(p0_ff) - 58'(p1_ff);
      ry_in = 58'(p2_ff) + 58'(p3_ff);
      // round half up at the Q.30 to Q.8 step
      rnd_x = rx_ff + 58'sd2097152;
      rnd_y = ry_ff + 58'sd2097152;
      sh_x  = 36'(rnd_x >>> 22);
      sh_y  = 36'(rnd_y >>> 22);
      px_in = sat32(37'(cfg.origin_x) + 37'(sh_x));
      py_in = sat32(37'(cfg.origin_y) + 37'(sh_y));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      lx_ff <= lx_in;
      ly_ff <= ly_in;
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      p3_ff <= p3_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      px_ff <= px_in;
      py_ff <= py_in;
   end

   assign done = v4_ff;
   assign px   = px_ff;
   assign py   = py_ff;

endmodule

// ----- hw/rtl/stroke_font_segment_generator_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stroke_font_segment_generator_top: vector stroke font segment generator
// Walks a glyph in the font memory and emits one line segment per pair of
// consecutive polyline points, placed, rotated and offset to world units.
// ---------------------------------------------------------------------------
// output: each segment is held until the next one forms or the glyph ends
// walk: each font word passes the memory read and the 4-stage placement
//   pipeline before the next one is fetched, and a new character is accepted
//   only once the previous one is done
// reset: synchronous; after reset the font and decode memories are loaded,
//   during which no character is accepted
module stroke_font_segment_generator_top
   import sfsg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // char_code[7:0], char_position[17:8]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // start_x, start_y, end_x, end_y (32 each)
   output logic         rsp_tlast,   // last_segment
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wr_data
);

   typedef enum logic [7:0] {
      S_CLR   = 8'b0000_0001,
      S_FILL  = 8'b0000_0010,
      S_IDLE  = 8'b0000_0100,
      S_INDEX = 8'b0000_1000,
      S_FETCH = 8'b0001_0000,
      S_XFORM = 8'b0010_0000,
      S_STEP  = 8'b0100_0000,
      S_FLUSH = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   cfg_type   cfg_ff, cfg_in;

   logic [ROM_AW-1:0] cnt_ff, cnt_in;
   logic              end_seen_ff, end_seen_in;
   logic [15:0]       pos60_ff, pos60_in;
   logic [ROM_AW-1:0] idx_ff, idx_in;
   logic              cont_ff, cont_in;
   logic              have_prev_ff, have_prev_in;
   logic [NSEG_W-1:0] nseg_ff, nseg_in;
   logic signed [31:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [31:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic              pend_ff, pend_in;
   logic [127:0]      pend_data_ff, pend_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [127:0]      rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [13:0]       fill_word;
   logic [7:0]        code;
   logic [9:0]        pos_sat;
   logic              out_free, push, push_last, seg_new, stall, walk_done;
   logic [ROM_AW:0]   next_addr, hdr_next;

   logic              rom_we, idx_we;
   logic [ROM_AW-1:0] rom_raddr;
   logic [13:0]       rom_rdata;
   logic [7:0]        idx_waddr, idx_raddr;
   logic [IDX_W-1:0]  idx_wdata, idx_rdata;

   logic              xf_start, xf_done;
   logic signed [31:0] xf_x, xf_y;

   sfsg_ram #(.WIDTH(14), .DEPTH(ROM_DEPTH)) u_font_ram (
      .clock   (clock),
      .wr_en   (rom_we),
      .wr_addr (cnt_ff),
      .wr_data (fill_word),
      .rd_addr (rom_raddr),
      .rd_data (rom_rdata)
   );

   sfsg_ram #(.WIDTH(IDX_W), .DEPTH(IDX_DEPTH)) u_decode_ram (
      .clock   (clock),
      .wr_en   (idx_we),
      .wr_addr (idx_waddr),
      .wr_data (idx_wdata),
      .rd_addr (idx_raddr),
      .rd_data (idx_rdata)
   );

   sfsg_xform u_xform (
      .clock (clock),
      .reset (reset),
      .start (xf_start),
      .pos60 (pos60_ff),
      .gx    (rom_rdata[11:6]),
      .gy    (rom_rdata[5:0]),
      .cfg   (cfg_ff),
      .done  (xf_done),
      .px    (xf_x),
      .py    (xf_y)
   );

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_SCALE:    cfg_in.scale    = csr_wr_data[23:0];
            REG_COS:      cfg_in.cos_rot  = csr_wr_data[15:0];
            REG_SIN:      cfg_in.sin_rot  = csr_wr_data[15:0];
            REG_ORIGIN_X: cfg_in.origin_x = csr_wr_data;
            REG_ORIGIN_Y: cfg_in.origin_y = csr_wr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      fill_word = font_word(int'(cnt_ff));
      code      = req_tdata[7:0];
      if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
         code = code - (CHAR_LOWER_A - CHAR_UPPER_A);
      end
      pos_sat = req_tdata[17:8];
      if (32'(req_tdata[17:8]) >= 32'(MAX_CHARS)) begin
         pos_sat = 10'(MAX_CHARS - 1);
      end
      pos60_in = pos60_ff;

      out_free  = !rsp_valid_ff || rsp_tready;
      seg_new   = cont_ff && have_prev_ff;
      stall     = seg_new && pend_ff && !out_free;
      next_addr = {1'b0, idx_ff} + 1'b1;
      hdr_next  = {1'b0, idx_rdata[ROM_AW-1:0]} + 1'b1;
      walk_done = (seg_new && nseg_ff == NSEG_W'(MAX_SEGS - 1))
                  || next_addr >= (ROM_AW + 1)'(ROM_LIM);

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      end_seen_in  = end_seen_ff;
      idx_in       = idx_ff;
      cont_in      = cont_ff;
      have_prev_in = have_prev_ff;
      nseg_in      = nseg_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      pend_in      = pend_ff;
      pend_data_in = pend_data_ff;
      push         = 1'b0;
      push_last    = 1'b0;
      rom_we       = 1'b0;
      idx_we       = 1'b0;
      idx_waddr    = cnt_ff[7:0];
      idx_wdata    = '0;
      idx_raddr    = code;
      rom_raddr    = idx_ff;
      xf_start     = 1'b0;
      req_tready   = 1'b0;

      unique case (state_ff)
         S_CLR: begin
            idx_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[7:0] == 8'hFF) begin
               cnt_in   = '0;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            rom_we    = 1'b1;
            idx_waddr = fill_word[7:0];
            idx_wdata = {1'b1, cnt_ff};
            idx_we    = !end_seen_ff && fill_word[13:12] == KIND_HEAD;
            if (fill_word[13:12] == KIND_END) begin
               end_seen_in = 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ROM_AW'(ROM_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               pos60_in = 16'(pos_sat) * 16'(CELL_TENTHS);
               state_in = S_INDEX;
            end
         end
         S_INDEX: begin
            have_prev_in = 1'b0;
            nseg_in      = '0;
            pend_in      = 1'b0;
            rom_raddr    = hdr_next[ROM_AW-1:0];
            idx_in       = hdr_next[ROM_AW-1:0];
            if (!idx_rdata[IDX_W-1] || hdr_next >= (ROM_AW + 1)'(ROM_LIM)) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (rom_rdata[13]) begin
               state_in = S_FLUSH;
            end else begin
               cont_in  = rom_rdata[13:12] == KIND_CONT;
               xf_start = 1'b1;
               state_in = S_XFORM;
            end
         end
         S_XFORM: begin
            if (xf_done) begin
               cur_x_in = xf_x;
               cur_y_in = xf_y;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            rom_raddr = next_addr[ROM_AW-1:0];
            if (!stall) begin
               if (seg_new) begin
                  push         = pend_ff;
                  pend_in      = 1'b1;
                  pend_data_in = {cur_y_ff, cur_x_ff, prev_y_ff, prev_x_ff};
                  nseg_in      = nseg_ff + 1'b1;
               end
               prev_x_in    = cur_x_ff;
               prev_y_in    = cur_y_ff;
               have_prev_in = 1'b1;
               idx_in       = next_addr[ROM_AW-1:0];
               state_in     = walk_done ? S_FLUSH : S_FETCH;
            end
         end
         S_FLUSH: begin
            if (!pend_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               pend_in   = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_CLR;
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pend_data_ff;
         rsp_last_in  = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_CLR;
         cnt_ff            <= '0;
         end_seen_ff       <= 1'b0;
         pend_ff           <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         have_prev_ff      <= 1'b0;
         nseg_ff           <= '0;
         cfg_ff.scale      <= SCALE_RESET;
         cfg_ff.cos_rot    <= COS_RESET;
         cfg_ff.sin_rot    <= '0;
         cfg_ff.origin_x   <= '0;
         cfg_ff.origin_y   <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         end_seen_ff  <= end_seen_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         have_prev_ff <= have_prev_in;
         nseg_ff      <= nseg_in;
         cfg_ff       <= cfg_in;
      end
      pos60_ff     <= pos60_in;
      idx_ff       <= idx_in;
      cont_ff      <= cont_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      pend_data_ff <= pend_data_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_seg_count: assert property (@(posedge clock) disable iff (reset)
      nseg_ff <= NSEG_W'(MAX_SEGS))
      else $error("segment count past limit");

   a_rom_write_fill: assert property (@(posedge clock) disable iff (reset)
      rom_we |-> state_ff == S_FILL)
      else $error("font memory written outside fill");

   a_xform_done: assert property (@(posedge clock) disable iff (reset)
      xf_done |-> state_ff == S_XFORM)
      else $error("placement result with no walk waiting");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("output overwritten while held");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the stroke font segment generator
// Streams characters with random handshake gaps, predicts every segment from
// an independent font walk and placement calculation, and compares beats.
// ---------------------------------------------------------------------------
module tb_top
   import sfsg_pkg::*;
();

   typedef struct packed {
      logic [9:0] char_position;
      logic [7:0] char_code;
   } char_item_type;

   typedef struct packed {
      logic        last_segment;
      logic [31:0] end_y;
      logic [31:0] end_x;
      logic [31:0] start_y;
      logic [31:0] start_x;
   } segment_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [23:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_wr_en = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_wr_data = '0;

   stroke_font_segment_generator_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the transform registers
   logic [23:0]        sh_scale = 24'd6554;
   logic signed [15:0] sh_cos   = 16'sd16384;
   logic signed [15:0] sh_sin   = 16'sd0;
   logic signed [31:0] sh_org_x = 32'sd0;
   logic signed [31:0] sh_org_y = 32'sd0;

   char_item_type pending_chars[$];
   segment_type   expected_segments[$];
   int            error_count = 0;
   int            char_count = 0;
   int            segment_count = 0;
   logic          calm = 1'b0;   // no idling while set

   // font word straight from the table, with the end mark past it
   function automatic logic [13:0] font_at(int a);
      if (a < ROM_ITEMS) return GLYPH_TABLE[a];
      return ROM_END;
   endfunction

   function automatic logic [31:0] world_coord(logic signed [31:0] org,
                                               longint q30);
      longint r;
      r = longint'(org) + ((q30 + 64'sd2097152) >>> 22);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   function automatic void place_point(int pos, int gx, int gy,
                                       output logic [31:0] wx,
                                       output logic [31:0] wy);
      longint lx, ly;
      lx = longint'(pos * CELL_TENTHS + gx) * longint'(sh_scale);
      ly = longint'(gy) * longint'(sh_scale);
      wx = world_coord(sh_org_x, lx * sh_cos - ly * sh_sin);
      wy = world_coord(sh_org_y, lx * sh_sin + ly * sh_cos);
   endfunction

   // walk the glyph and queue its segments
   function automatic void predict_segments(char_item_type it);
      logic [7:0] code;
      int pos, a, head, n, px, py, cx, cy;
      logic [13:0] w;
      logic have_prev;
      segment_type s;
      code = it.char_code;
      pos = it.char_position;
      if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z)
         code = code - CHAR_LOWER_A + CHAR_UPPER_A;
      if (pos >= MAX_CHARS) pos = MAX_CHARS - 1;
      head = -1;
      for (a = 0; a < ROM_LIM; a++) begin
         w = font_at(a);
         if (w[13:12] == KIND_END) break;
         if (w[13:12] == KIND_HEAD && w[7:0] == code) head = a;
      end
      if (head < 0) return;
      n = 0; have_prev = 1'b0; px = 0; py = 0;
      for (a = head + 1; a < ROM_LIM && n < MAX_SEGS; a++) begin
         w = font_at(a);
         if (w[13:12] == KIND_HEAD || w[13:12] == KIND_END) break;
         cx = w[11:6]; cy = w[5:0];
         if (w[13:12] == KIND_CONT && have_prev) begin
            place_point(pos, px, py, s.start_x, s.start_y);
            place_point(pos, cx, cy, s.end_x, s.end_y);
            s.last_segment = 1'b0;
            expected_segments.push_back(s);
            n++;
         end
         px = cx; py = cy; have_prev = 1'b1;
      end
      if (n > 0) expected_segments[$].last_segment = 1'b1;
   endfunction

   task automatic report_error(string msg);
      $display("mismatch %s", msg);
      error_count++;
   endtask

   task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_error($sformatf("%s: got %h want %h", what, got, want));
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            predict_segments(char_item_type'(req_tdata[17:0]));
            char_count++;
         end
         if (pending_chars.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
            req_tdata  <= {6'd0, pending_chars.pop_front()};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      segment_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tlast, rsp_tdata};
            segment_count++;
            if (expected_segments.size() == 0) begin
               report_error($sformatf("unexpected segment beat %h", got));
            end else begin
               want = expected_segments.pop_front();
               check_field("start_x", got.start_x, want.start_x);
               check_field("start_y", got.start_y, want.start_y);
               check_field("end_x", got.end_x, want.end_x);
               check_field("end_y", got.end_y, want.end_y);
               check_field("last_segment", 32'(got.last_segment),
                           32'(want.last_segment));
            end
         end
         rsp_tready <= calm || $urandom_range(99) >= 13;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wr_data <= val;
      case (idx)
         REG_SCALE:    sh_scale = val[23:0];
         REG_COS:      sh_cos   = val[15:0];
         REG_SIN:      sh_sin   = val[15:0];
         REG_ORIGIN_X: sh_org_x = val;
         REG_ORIGIN_Y: sh_org_y = val;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain;
      while (pending_chars.size() > 0 || req_tvalid || expected_segments.size() > 0)
         @(posedge clock);
      repeat (150) @(posedge clock);   // blank characters may still be walking
   endtask

   task automatic set_transform(logic [23:0] sc, logic [15:0] c, logic [15:0] s,
                                logic [31:0] ox, logic [31:0] oy);
      write_reg(REG_SCALE, {8'd0, sc});
      write_reg(REG_COS, {16'd0, c});
      write_reg(REG_SIN, {16'd0, s});
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
   endtask

   function automatic logic [7:0] pick_code();
      int r;
      r = $urandom_range(99);
      if (r < 40) return 8'(8'h41 + $urandom_range(25));
      if (r < 60) return 8'(CHAR_LOWER_A + $urandom_range(25));
      if (r < 80) return 8'(8'h30 + $urandom_range(9));
      return 8'($urandom_range(255));
   endfunction

   task automatic random_phase(int count);
      repeat (count) pending_chars.push_back({10'($urandom_range(1023)), pick_code()});
   endtask

   initial begin
      string glyphs;
      int i;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, every kind of glyph, blank, unknown, case folding
      glyphs = "A8%QSz.-, ";
      for (i = 0; i < glyphs.len(); i++)
         pending_chars.push_back({10'(i), glyphs[i]});
      pending_chars.push_back({10'd1023, 8'hD8});
      pending_chars.push_back({10'd0, 8'hB0});
      pending_chars.push_back({10'd1023, 8'hFF});
      pending_chars.push_back({10'd512, 8'h00});
      pending_chars.push_back({10'd341, 8'hF8});   // lowercase o-slash does not fold
      pending_chars.push_back({10'd682, 8'h7A});
      drain();
      set_transform(24'hFFFFFF, 16'hC000, 16'h4000, 32'h7FFFFFFF, 32'h80000000);
      pending_chars.push_back({10'd1023, 8'h38});
      pending_chars.push_back({10'd0, 8'h4D});
      random_phase(60);
      drain();
      set_transform(24'd0, 16'h8000, 16'h7FFF, 32'h80000000, 32'h7FFFFFFF);
      random_phase(30);
      drain();
      set_transform(24'd6554, 16'sd11585, 16'sd11585, 32'h00012345, 32'hFFFE0000);
      calm = 1'b1;
      random_phase(80);
      drain();
      calm = 1'b0;
      set_transform(24'($urandom), 16'($urandom_range(32768) - 16384),
                    16'($urandom_range(32768) - 16384), $urandom, $urandom);
      random_phase(110);
      drain();
      $display("sent %0d characters through five transform settings, checked %0d segments",
               char_count, segment_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/sfsg_pkg.sv
hw/rtl/sfsg_ram.sv
hw/rtl/sfsg_xform.sv
hw/rtl/stroke_font_segment_generator_top.sv
verif/tb_top.sv
